>>> design/iir_lp_pkg.sv
// iir_lp_pkg: shared widths, coefficient tables, control-word types and the
// microcode program of the sixth-order direct-form-I low-pass filter
// no dependencies
`timescale 1ns / 1ps

package iir_lp_pkg;

    localparam int MAX_ORDER = 12;
    localparam int TAP_W     = 4;
    localparam int PC_W      = 4;
    localparam int COEF_W    = 32;
    localparam int CHUNK_W   = 24;
    localparam int MUL_B_W   = CHUNK_W + 1;
    localparam int PROD_W    = COEF_W + MUL_B_W;
    localparam int ACC_W     = 64;
    localparam int GAIN_W    = 16;
    localparam int GS_W      = 81;
    localparam int Y_W       = 48;
    localparam int FB_HI_SHIFT = 6;
    localparam int FB_LO_SHIFT = 18;
    localparam int GAIN_SHIFT  = 23;

    localparam logic signed [GAIN_W-1:0] GAIN_RESET = 16'sd22938;
    localparam logic signed [GS_W-1:0]   GS_ROUND   = GS_W'(1) <<< (GAIN_SHIFT - 1);

    typedef logic [PC_W-1:0]  t_pc;
    typedef logic [TAP_W-1:0] t_tap;

    typedef enum logic [2:0] {
        MUL_NONE, MUL_FF, MUL_FB_HI, MUL_FB_LO, MUL_G0, MUL_G1, MUL_G2
    } t_mul_sel;

    typedef enum logic [2:0] {
        ACC_HOLD, ACC_CLR, ACC_ADD, ACC_ADD_FLOOR, ACC_ADD_L6, ACC_ADD_R18
    } t_acc_op;

    typedef enum logic [2:0] {
        GS_HOLD, GS_INIT, GS_ADD0, GS_ADD24, GS_ADD48
    } t_gs_op;

    typedef enum logic [1:0] {
        CNT_HOLD, CNT_CLR, CNT_SET1, CNT_INC
    } t_cnt_op;

    typedef enum logic [1:0] {
        JMP_NEXT, JMP_LOOP, JMP_WAIT_IN, JMP_WAIT_OUT
    } t_jmp;

    typedef struct packed {
        t_mul_sel mul;
        t_acc_op  acc;
        t_gs_op   gs;
        t_cnt_op  cnt;
        t_jmp     jmp;
        t_pc      target;
        logic     load_x;
        logic     finish;
    } t_uop;

    typedef struct packed {
        t_uop uop;
        t_tap tap;
        logic go;
    } t_ctrl;

    typedef struct packed {
        logic in_valid;
        logic out_free;
    } t_seq_stat;

    // program addresses
    localparam t_pc A_WAIT   = 4'd0;
    localparam t_pc A_FF     = 4'd1;
    localparam t_pc A_FF_END = 4'd2;
    localparam t_pc A_FB_HI  = 4'd3;
    localparam t_pc A_FB_LO  = 4'd4;
    localparam t_pc A_FB_END = 4'd5;
    localparam t_pc A_G0     = 4'd6;
    localparam t_pc A_G1     = 4'd7;
    localparam t_pc A_G2     = 4'd8;
    localparam t_pc A_G_END  = 4'd9;
    localparam t_pc A_DONE   = 4'd10;

    function automatic t_uop mk_uop(t_mul_sel mul, t_acc_op acc, t_gs_op gs,
                                    t_cnt_op cnt, t_jmp jmp, t_pc target,
                                    logic load_x, logic finish);
        t_uop u;
        u.mul    = mul;
        u.acc    = acc;
        u.gs     = gs;
        u.cnt    = cnt;
        u.jmp    = jmp;
        u.target = target;
        u.load_x = load_x;
        u.finish = finish;
        return u;
    endfunction

    // control store
    function automatic t_uop ucode(t_pc pc);
        t_uop u;
        case (pc)
            A_WAIT:   u = mk_uop(MUL_NONE, ACC_CLR, GS_HOLD, CNT_CLR, JMP_WAIT_IN,
                                 A_WAIT, 1'b1, 1'b0);
            A_FF:     u = mk_uop(MUL_FF, ACC_ADD, GS_HOLD, CNT_INC, JMP_LOOP,
                                 A_FF, 1'b0, 1'b0);
            A_FF_END: u = mk_uop(MUL_NONE, ACC_ADD_FLOOR, GS_HOLD, CNT_SET1, JMP_NEXT,
                                 A_WAIT, 1'b0, 1'b0);
            A_FB_HI:  u = mk_uop(MUL_FB_HI, ACC_ADD_R18, GS_HOLD, CNT_HOLD, JMP_NEXT,
                                 A_WAIT, 1'b0, 1'b0);
            A_FB_LO:  u = mk_uop(MUL_FB_LO, ACC_ADD_L6, GS_HOLD, CNT_INC, JMP_LOOP,
                                 A_FB_HI, 1'b0, 1'b0);
            A_FB_END: u = mk_uop(MUL_NONE, ACC_ADD_R18, GS_HOLD, CNT_HOLD, JMP_NEXT,
                                 A_WAIT, 1'b0, 1'b0);
            A_G0:     u = mk_uop(MUL_G0, ACC_HOLD, GS_INIT, CNT_HOLD, JMP_NEXT,
                                 A_WAIT, 1'b0, 1'b0);
            A_G1:     u = mk_uop(MUL_G1, ACC_HOLD, GS_ADD0, CNT_HOLD, JMP_NEXT,
                                 A_WAIT, 1'b0, 1'b0);
            A_G2:     u = mk_uop(MUL_G2, ACC_HOLD, GS_ADD24, CNT_HOLD, JMP_NEXT,
                                 A_WAIT, 1'b0, 1'b0);
            A_G_END:  u = mk_uop(MUL_NONE, ACC_HOLD, GS_ADD48, CNT_HOLD, JMP_NEXT,
                                 A_WAIT, 1'b0, 1'b0);
            A_DONE:   u = mk_uop(MUL_NONE, ACC_HOLD, GS_HOLD, CNT_HOLD, JMP_WAIT_OUT,
                                 A_WAIT, 1'b0, 1'b1);
            default:  u = mk_uop(MUL_NONE, ACC_HOLD, GS_HOLD, CNT_HOLD, JMP_WAIT_OUT,
                                 A_WAIT, 1'b0, 1'b0);
        endcase
        return u;
    endfunction

    // feedforward taps, scaled 2^-60
    function automatic logic signed [COEF_W-1:0] ff_coef(t_tap tap);
        logic signed [COEF_W-1:0] c;
        case (tap)
            4'd0:    c = -32'sd1647340;
            4'd1:    c = -32'sd9884042;
            4'd2:    c = -32'sd24710104;
            4'd3:    c = -32'sd32946805;
            4'd4:    c = -32'sd24710104;
            4'd5:    c = -32'sd9884042;
            4'd6:    c = -32'sd1647340;
            default: c = '0;
        endcase
        return c;
    endfunction

    // feedback taps, Q5.26
    function automatic logic signed [COEF_W-1:0] fb_coef(t_tap tap);
        logic signed [COEF_W-1:0] c;
        case (tap)
            4'd1:    c = 32'sd397109992;
            4'd2:    c = -32'sd979151880;
            4'd3:    c = 32'sd1287671461;
            4'd4:    c = -32'sd952570059;
            4'd5:    c = 32'sd375843193;
            4'd6:    c = -32'sd61787131;
            default: c = '0;
        endcase
        return c;
    endfunction

endpackage

>>> design/iir_lp_seq.sv
// iir_lp_seq: microcode sequencer, step counter, tap counter and jump logic
// depends on iir_lp_pkg
`timescale 1ns / 1ps

module iir_lp_seq #(
    parameter int FILTER_ORDER = 6
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  iir_lp_pkg::t_seq_stat i_stat,
    output iir_lp_pkg::t_ctrl     o_ctrl
);

    localparam int TW = iir_lp_pkg::TAP_W;

    iir_lp_pkg::t_pc  r_pc,  n_pc;
    iir_lp_pkg::t_tap r_tap, n_tap;
    iir_lp_pkg::t_uop uop;
    logic             go;
    logic             loop_more;

    assign uop       = iir_lp_pkg::ucode(r_pc);
    assign loop_more = (r_tap != TW'(FILTER_ORDER));

    always_comb begin
        case (uop.jmp)
            iir_lp_pkg::JMP_WAIT_IN:  go = i_stat.in_valid;
            iir_lp_pkg::JMP_WAIT_OUT: go = i_stat.out_free;
            default:                  go = 1'b1;
        endcase
    end

    always_comb begin
        case (uop.jmp)
            iir_lp_pkg::JMP_NEXT:     n_pc = r_pc + 1'b1;
            iir_lp_pkg::JMP_LOOP:     n_pc = loop_more ? uop.target : r_pc + 1'b1;
            iir_lp_pkg::JMP_WAIT_IN:  n_pc = go ? r_pc + 1'b1 : r_pc;
            iir_lp_pkg::JMP_WAIT_OUT: n_pc = go ? uop.target : r_pc;
            default:                  n_pc = iir_lp_pkg::A_WAIT;
        endcase
    end

    always_comb begin
        n_tap = r_tap;
        if (go) begin
            case (uop.cnt)
                iir_lp_pkg::CNT_CLR:  n_tap = '0;
                iir_lp_pkg::CNT_SET1: n_tap = TW'(1);
                iir_lp_pkg::CNT_INC:  n_tap = r_tap + 1'b1;
                default:              n_tap = r_tap;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc  <= iir_lp_pkg::A_WAIT;
            r_tap <= '0;
        end else begin
            r_pc  <= n_pc;
            r_tap <= n_tap;
        end
    end

    assign o_ctrl.uop = uop;
    assign o_ctrl.tap = r_tap;
    assign o_ctrl.go  = go;

endmodule

>>> design/iir_lp_dp.sv
// iir_lp_dp: shared multiplier, accumulators, sample histories and dac conversion
// depends on iir_lp_pkg, driven by iir_lp_seq control words
`timescale 1ns / 1ps

module iir_lp_dp #(
    parameter int FILTER_ORDER = 6,
    parameter int SAMPLE_BITS  = 12
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  iir_lp_pkg::t_ctrl                     i_ctrl,
    input  logic [SAMPLE_BITS-1:0]                i_sample,
    input  logic signed [iir_lp_pkg::GAIN_W-1:0]  i_gain,
    output logic [SAMPLE_BITS-1:0]                o_code,
    output logic                                  o_clip
);

    localparam int CW  = iir_lp_pkg::COEF_W;
    localparam int BW  = iir_lp_pkg::MUL_B_W;
    localparam int PW  = iir_lp_pkg::PROD_W;
    localparam int AW  = iir_lp_pkg::ACC_W;
    localparam int GW  = iir_lp_pkg::GS_W;
    localparam int YW  = iir_lp_pkg::Y_W;
    localparam int HW  = iir_lp_pkg::CHUNK_W;
    localparam int TW  = iir_lp_pkg::TAP_W;
    localparam int GSH = iir_lp_pkg::GAIN_SHIFT;
    localparam int FF_SHIFT  = SAMPLE_BITS + 11;
    localparam int DAC_SHIFT = 41 - SAMPLE_BITS;
    localparam logic signed [YW:0] HALF_CODE = (YW+1)'(1) <<< (SAMPLE_BITS - 1);
    localparam logic signed [YW:0] CODE_MAX  = ((YW+1)'(1) <<< SAMPLE_BITS) - (YW+1)'(1);

    logic signed [SAMPLE_BITS-1:0] r_x;
    logic signed [SAMPLE_BITS-1:0] r_hist_x [FILTER_ORDER];
    logic signed [YW-1:0]          r_hist_y [FILTER_ORDER];
    logic signed [PW-1:0]          r_prod;
    logic signed [AW-1:0]          r_acc;
    logic signed [GW-1:0]          r_gsum;

    logic signed [SAMPLE_BITS-1:0] x_in, x_sel;
    logic signed [YW-1:0]          y_sel;
    logic signed [CW-1:0]          mul_a;
    logic signed [BW-1:0]          mul_b;
    logic signed [PW-1:0]          prod_c;
    logic signed [AW-1:0]          prod_acc, acc_sum, n_acc;
    logic signed [GW-1:0]          prod_gs, n_gsum;
    logic signed [GW-GSH-1:0]      y_wide;
    logic signed [YW-1:0]          y_sat;
    logic signed [YW:0]            dac_bias, dac_t, dac_code_w;
    logic                          step_go;
    logic                          finish_go;

    assign step_go   = i_ctrl.go;
    assign finish_go = i_ctrl.go && i_ctrl.uop.finish;

    // centre the converter sample: flip the msb
    assign x_in = {~i_sample[SAMPLE_BITS-1], i_sample[SAMPLE_BITS-2:0]};

    // history tap select
    always_comb begin
        x_sel = r_x;
        y_sel = '0;
        for (int j = 0; j < FILTER_ORDER; j++) begin
            if (i_ctrl.tap == TW'(j + 1)) begin
                x_sel = r_hist_x[j];
                y_sel = r_hist_y[j];
            end
        end
    end

    // operand select for the shared multiplier
    always_comb begin
        case (i_ctrl.uop.mul)
            iir_lp_pkg::MUL_FF: begin
                mul_a = iir_lp_pkg::ff_coef(i_ctrl.tap);
                mul_b = BW'(x_sel);
            end
            iir_lp_pkg::MUL_FB_HI: begin
                mul_a = iir_lp_pkg::fb_coef(i_ctrl.tap);
                mul_b = BW'($signed(y_sel[YW-1:HW]));
            end
            iir_lp_pkg::MUL_FB_LO: begin
                mul_a = iir_lp_pkg::fb_coef(i_ctrl.tap);
                mul_b = {1'b0, y_sel[HW-1:0]};
            end
            iir_lp_pkg::MUL_G0: begin
                mul_a = CW'(i_gain);
                mul_b = {1'b0, r_acc[HW-1:0]};
            end
            iir_lp_pkg::MUL_G1: begin
                mul_a = CW'(i_gain);
                mul_b = {1'b0, r_acc[2*HW-1:HW]};
            end
            iir_lp_pkg::MUL_G2: begin
                mul_a = CW'(i_gain);
                mul_b = BW'($signed(r_acc[AW-1:2*HW]));
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_c = mul_a * mul_b;

    // tap accumulator, scale 2^-48 once the feedforward sum is floored
    assign prod_acc = AW'(r_prod);
    assign acc_sum  = r_acc + prod_acc;

    always_comb begin
        case (i_ctrl.uop.acc)
            iir_lp_pkg::ACC_CLR:       n_acc = '0;
            iir_lp_pkg::ACC_ADD:       n_acc = acc_sum;
            iir_lp_pkg::ACC_ADD_FLOOR: n_acc = acc_sum >>> FF_SHIFT;
            iir_lp_pkg::ACC_ADD_L6:    n_acc = r_acc + (prod_acc <<< iir_lp_pkg::FB_HI_SHIFT);
            iir_lp_pkg::ACC_ADD_R18:   n_acc = r_acc + (prod_acc >>> iir_lp_pkg::FB_LO_SHIFT);
            default:                   n_acc = r_acc;
        endcase
    end

    // gain sum, exact product of gain and accumulator plus half lsb
    assign prod_gs = GW'(r_prod);

    always_comb begin
        case (i_ctrl.uop.gs)
            iir_lp_pkg::GS_INIT:  n_gsum = iir_lp_pkg::GS_ROUND;
            iir_lp_pkg::GS_ADD0:  n_gsum = r_gsum + prod_gs;
            iir_lp_pkg::GS_ADD24: n_gsum = r_gsum + (prod_gs <<< HW);
            iir_lp_pkg::GS_ADD48: n_gsum = r_gsum + (prod_gs <<< (2 * HW));
            default:              n_gsum = r_gsum;
        endcase
    end

    // round by floor after the half lsb, then saturate to q7.40
    assign y_wide = r_gsum[GW-1:GSH];

    always_comb begin
        if ((&y_wide[GW-GSH-1:YW-1]) || !(|y_wide[GW-GSH-1:YW-1])) begin
            y_sat = y_wide[YW-1:0];
        end else if (y_wide[GW-GSH-1]) begin
            y_sat = {1'b1, {(YW-1){1'b0}}};
        end else begin
            y_sat = {1'b0, {(YW-1){1'b1}}};
        end
    end

    // dac code: truncate toward zero, add mid-scale, clamp
    assign dac_bias   = y_sat[YW-1] ? {{(YW+1-DAC_SHIFT){1'b0}}, {DAC_SHIFT{1'b1}}} : '0;
    assign dac_t      = ((YW+1)'(y_sat) + dac_bias) >>> DAC_SHIFT;
    assign dac_code_w = dac_t + HALF_CODE;

    always_comb begin
        if (dac_code_w[YW]) begin
            o_code = '0;
            o_clip = 1'b1;
        end else if (dac_code_w > CODE_MAX) begin
            o_code = '1;
            o_clip = 1'b1;
        end else begin
            o_code = dac_code_w[SAMPLE_BITS-1:0];
            o_clip = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= prod_c;
        if (step_go) begin
            r_acc  <= n_acc;
            r_gsum <= n_gsum;
        end
        if (step_go && i_ctrl.uop.load_x) begin
            r_x <= x_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < FILTER_ORDER; j++) begin
                r_hist_x[j] <= '0;
                r_hist_y[j] <= '0;
            end
        end else if (finish_go) begin
            for (int j = FILTER_ORDER - 1; j > 0; j--) begin
                r_hist_x[j] <= r_hist_x[j-1];
                r_hist_y[j] <= r_hist_y[j-1];
            end
            r_hist_x[0] <= r_x;
            r_hist_y[0] <= y_sat;
        end
    end

endmodule

>>> design/iir_lowpass_order6_df1.sv
// iir_lowpass_order6_df1: top level of the direct-form-I low-pass filter
// depends on iir_lp_pkg, iir_lp_seq and iir_lp_dp
`timescale 1ns / 1ps

//  channel   | direction | handshake          | payload
//  ----------+-----------+--------------------+-------------------------------
//  sample    | in        | i_valid / o_stall  | i_adc_sample
//  result    | out       | o_valid / i_stall  | o_dac_code, o_clipped
//  gain cfg  | in        | i_cfg_wr_en        | i_cfg_wr_data (signed q1.15)
//
//  a sample's run from acceptance to the next acceptance is spent mostly on
//  the single shared 32x25 multiplier: one pass per feedforward tap, two
//  per feedback tap, three for the gain
//  synchronous active-low reset clears the step counter, the histories,
//  the gain (to 0.7) and the result valid flag
//  the result register lets the next sample in while a result waits; the
//  last step of the program holds while an earlier result is still unclaimed

module iir_lowpass_order6_df1 #(
    parameter int FILTER_ORDER = 6,
    parameter int SAMPLE_BITS  = 12
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // sample channel
    input  logic                                  i_valid,
    output logic                                  o_stall,
    input  logic [SAMPLE_BITS-1:0]                i_adc_sample,
    // result channel
    output logic                                  o_valid,
    input  logic                                  i_stall,
    output logic [SAMPLE_BITS-1:0]                o_dac_code,
    output logic                                  o_clipped,
    // gain register write
    input  logic                                  i_cfg_wr_en,
    input  logic [iir_lp_pkg::GAIN_W-1:0]         i_cfg_wr_data
);

    iir_lp_pkg::t_ctrl     ctrl;
    iir_lp_pkg::t_seq_stat stat;

    logic signed [iir_lp_pkg::GAIN_W-1:0] r_gain;
    logic                                 r_out_valid;
    logic [SAMPLE_BITS-1:0]               r_dac_code;
    logic                                 r_clipped;
    logic [SAMPLE_BITS-1:0]               dp_code;
    logic                                 dp_clip;
    logic                                 out_free;
    logic                                 finish_go;

    // result slot is free when empty or being taken this cycle
    assign out_free      = !r_out_valid || !i_stall;
    assign stat.in_valid = i_valid;
    assign stat.out_free = out_free;

    // only the wait step takes a sample
    assign o_stall   = (ctrl.uop.jmp != iir_lp_pkg::JMP_WAIT_IN);
    assign finish_go = ctrl.go && ctrl.uop.finish;

    iir_lp_seq #(
        .FILTER_ORDER (FILTER_ORDER)
    ) u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (stat),
        .o_ctrl  (ctrl)
    );

    iir_lp_dp #(
        .FILTER_ORDER (FILTER_ORDER),
        .SAMPLE_BITS  (SAMPLE_BITS)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (ctrl),
        .i_sample (i_adc_sample),
        .i_gain   (r_gain),
        .o_code   (dp_code),
        .o_clip   (dp_clip)
    );

    // gain register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain <= iir_lp_pkg::GAIN_RESET;
        end else if (i_cfg_wr_en) begin
            r_gain <= i_cfg_wr_data;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (finish_go) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (finish_go) begin
            r_dac_code <= dp_code;
            r_clipped  <= dp_clip;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_dac_code = r_dac_code;
    assign o_clipped  = r_clipped;

endmodule

>>> design/iir_lp_chk.sv
// iir_lp_chk: port-level checks on the filter top level, with its bind
// depends on iir_lowpass_order6_df1 port names
`timescale 1ns / 1ps

module iir_lp_chk #(
    parameter int SAMPLE_BITS = 12
) (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_valid,
    input logic                   o_stall,
    input logic                   o_valid,
    input logic                   i_stall,
    input logic [SAMPLE_BITS-1:0] o_dac_code,
    input logic                   o_clipped
);

    // a waiting result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_dac_code) && $stable(o_clipped))
        else $error("result changed while stalled");

    // clip flag only at the code rails
    a_clip_rail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_clipped |-> (o_dac_code == '0) || (o_dac_code == '1))
        else $error("clip flag set away from the code rails");

    // a sample transaction starts the program, so the input is busy next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("input not busy after a sample transaction");

    // a new result comes from the last step, which was busy and returns to wait
    a_result_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(o_stall) && !o_stall)
        else $error("result appeared outside the last program step");

endmodule

bind iir_lowpass_order6_df1 iir_lp_chk #(.SAMPLE_BITS(SAMPLE_BITS)) u_iir_lp_chk (.*);

>>> bench/iir_lowpass_order6_df1_tb.sv
// iir_lowpass_order6_df1_tb: self-checking bench for the sixth-order low-pass filter
// drives sample transactions and gain writes, predicts every dac code in a scoreboard class
// depends on iir_lp_pkg and iir_lowpass_order6_df1
`timescale 1ns / 1ps

module iir_lowpass_order6_df1_tb;

    localparam int  SAMPLE_W      = 12;
    localparam int  TAPS          = 6;
    localparam int  SETTLE_CYCLES = 40;      // comfortably above one sample's program run
    localparam int  CYCLE_LIMIT   = 600000;
    localparam int  PHASE_ITEMS   = 80;
    localparam int  FLUSH_ITEMS   = 8;
    localparam logic [15:0] GAIN_DEFAULT = 16'd22938;

    typedef struct packed {
        logic [SAMPLE_W-1:0] code;
        logic                clip;
    } t_dac_result;

    // ------------------------------------------------------------------
    // filter predictor plus the queue of dac codes still owed by the block
    // ------------------------------------------------------------------
    class dac_code_tracker;
        longint      gain_q15;
        longint      x_hist[TAPS];   // centred samples, newest first
        longint      y_hist[TAPS];   // q7.40 outputs, newest first
        t_dac_result owed_codes[$];
        int          fail_count;

        function void clear_state();
            gain_q15 = longint'($signed(GAIN_DEFAULT));
            for (int k = 0; k < TAPS; k++) begin
                x_hist[k] = 0;
                y_hist[k] = 0;
            end
            owed_codes.delete();
            fail_count = 0;
        endfunction

        function void set_gain(logic [15:0] g);
            gain_q15 = longint'($signed(g));
        endfunction

        function int outstanding();
            return owed_codes.size();
        endfunction

        // feedforward weights, scaled 2^-60
        function longint ff_weight(int k);
            case (k)
                0, 6:    return -64'sd1647340;
                1, 5:    return -64'sd9884042;
                2, 4:    return -64'sd24710104;
                3:       return -64'sd32946805;
                default: return 64'sd0;
            endcase
        endfunction

        // feedback weights, q5.26
        function longint fb_weight(int k);
            case (k)
                1:       return 64'sd397109992;
                2:       return -64'sd979151880;
                3:       return 64'sd1287671461;
                4:       return -64'sd952570059;
                5:       return 64'sd375843193;
                6:       return -64'sd61787131;
                default: return 64'sd0;
            endcase
        endfunction

        function void log_sample(logic [SAMPLE_W-1:0] s);
            longint      x, ff, acc, hi, lo, y, t, code;
            t_dac_result r;
            x  = $signed({52'd0, s}) - 64'sd2048;
            ff = ff_weight(0) * x;
            for (int k = 1; k <= TAPS; k++)
                ff += ff_weight(k) * x_hist[k-1];
            acc = ff >>> 23;
            // feedback products split into 24-bit halves, each floored to 2^-48
            for (int k = 1; k <= TAPS; k++) begin
                hi  = y_hist[k-1] >>> 24;
                lo  = y_hist[k-1] - (hi <<< 24);
                acc += fb_weight(k) * hi * 64 + ((fb_weight(k) * lo) >>> 18);
            end
            // gain, rounded half up to 2^-40
            hi = acc >>> 24;
            lo = acc - (hi <<< 24);
            y  = gain_q15 * hi * 2 + ((gain_q15 * lo + 64'sd4194304) >>> 23);
            if (y > 64'sd140737488355327)
                y = 64'sd140737488355327;
            if (y < -64'sd140737488355328)
                y = -64'sd140737488355328;
            for (int k = TAPS - 1; k > 0; k--) begin
                x_hist[k] = x_hist[k-1];
                y_hist[k] = y_hist[k-1];
            end
            x_hist[0] = x;
            y_hist[0] = y;
            // truncation toward zero, offset, clamp
            if (y >= 0)
                t = y >>> 29;
            else
                t = -((-y) >>> 29);
            code   = t + 2048;
            r.clip = 1'b0;
            if (code < 0) begin
                code   = 0;
                r.clip = 1'b1;
            end else if (code > 4095) begin
                code   = 4095;
                r.clip = 1'b1;
            end
            r.code = code[SAMPLE_W-1:0];
            owed_codes.push_back(r);
        endfunction

        function void compare_dac(logic [SAMPLE_W-1:0] code, logic clip);
            t_dac_result want;
            if (owed_codes.size() == 0) begin
                $error("result transaction with no sample outstanding: dac_code %0d", code);
                fail_count++;
                return;
            end
            want = owed_codes.pop_front();
            if (code !== want.code) begin
                $error("dac_code mismatch: expected %0d, actual %0d", want.code, code);
                fail_count++;
            end
            if (clip !== want.clip) begin
                $error("clipped mismatch: expected %0d, actual %0d", want.clip, clip);
                fail_count++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------
    // block hookup
    // ------------------------------------------------------------------
    logic                        i_clk;
    logic                        i_rst_n;
    logic                        i_valid;
    logic                        o_stall;
    logic [SAMPLE_W-1:0]         i_adc_sample;
    logic                        o_valid;
    logic                        i_stall;
    logic [SAMPLE_W-1:0]         o_dac_code;
    logic                        o_clipped;
    logic                        i_cfg_wr_en;
    logic [iir_lp_pkg::GAIN_W-1:0] i_cfg_wr_data;

    iir_lowpass_order6_df1 #(
        .FILTER_ORDER (6),
        .SAMPLE_BITS  (SAMPLE_W)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_adc_sample  (i_adc_sample),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_dac_code    (o_dac_code),
        .o_clipped     (o_clipped),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data)
    );

    dac_code_tracker tracker;
    bit              src_calm;   // sender idles not at all while set
    bit              snk_calm;   // receiver never stalls while set
    int              cycle_count;

    // 2 ns clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // watchdog: a hung handshake ends the run as a failure
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("FAILURE");
        $finish;
    end

    function automatic int draw_wait(bit calm);
        return calm ? 0 : $urandom_range(0, 10);
    endfunction

    // one sample transaction; valid stays high across back-to-back items
    task automatic send_sample(input logic [SAMPLE_W-1:0] s);
        int gap;
        gap = draw_wait(src_calm);
        repeat (gap) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_valid      <= 1'b1;
        i_adc_sample <= s;
        do @(posedge i_clk); while (o_stall);
        tracker.log_sample(s);
    endtask

    // mostly uniform codes, with a share at the rails and near mid-scale
    function automatic logic [SAMPLE_W-1:0] draw_sample();
        case ($urandom_range(0, 9))
            0:       return 12'd0;
            1:       return 12'd4095;
            2:       return 12'($urandom_range(2038, 2058));
            default: return 12'($urandom_range(0, 4095));
        endcase
    endfunction

    // gain write once the filter has drained and gone quiet
    task automatic write_gain(input logic [15:0] g);
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (tracker.outstanding() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= g;
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        i_cfg_wr_data <= 16'($urandom_range(0, 65535));
        tracker.set_gain(g);
    endtask

    // result side: draw a stall length per result, then claim it
    task automatic claim_results();
        int st;
        forever begin
            st = draw_wait(snk_calm);
            repeat (st) begin
                @(negedge i_clk);
                i_stall <= 1'b1;
            end
            @(negedge i_clk);
            i_stall <= 1'b0;
            do @(posedge i_clk); while (!o_valid);
            tracker.compare_dac(o_dac_code, o_clipped);
        end
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin
        logic [15:0] phase_gain;
        tracker       = new;
        src_calm      = 1'b0;
        snk_calm      = 1'b0;
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_adc_sample  = '0;
        i_stall       = 1'b0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_wr_data = '0;
        tracker.clear_state();
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        fork
            claim_results();
        join_none

        // directed: rails, mid-scale neighbours and a full-swing toggle at reset gain
        send_sample(12'd4095);
        send_sample(12'd4095);
        send_sample(12'd4095);
        send_sample(12'd0);
        send_sample(12'd0);
        send_sample(12'd0);
        send_sample(12'd2048);
        send_sample(12'd2047);
        send_sample(12'd2049);
        send_sample(12'd1);
        send_sample(12'd4094);
        for (int i = 0; i < 6; i++)
            send_sample(i[0] ? 12'd4095 : 12'd0);
        send_sample(12'hAAA);
        send_sample(12'h555);

        // random phases: flush history at zero gain, then run at the phase gain
        for (int p = 0; p < 12; p++) begin
            case (p)
                0:       phase_gain = 16'h7FFF;      // just below +1.0
                1:       phase_gain = 16'h8000;      // -1.0
                2:       phase_gain = 16'h0000;
                3:       phase_gain = 16'h0001;
                4:       phase_gain = 16'hFFFF;
                5:       phase_gain = GAIN_DEFAULT;
                default: phase_gain = ($urandom_range(0, 1) != 0) ?
                                      16'($urandom_range(16000, 26000)) :
                                      16'($urandom_range(0, 65535));
            endcase
            src_calm = ($urandom_range(0, 3) == 0);
            snk_calm = ($urandom_range(0, 3) == 0);

            // zero gain drives y to zero, which clears any saturated history
            write_gain(16'h0000);
            for (int i = 0; i < FLUSH_ITEMS; i++)
                send_sample(draw_sample());

            write_gain(phase_gain);
            for (int i = 0; i < PHASE_ITEMS; i++)
                send_sample(draw_sample());
        end

        @(negedge i_clk);
        i_valid <= 1'b0;
        snk_calm = 1'b0;
        while (tracker.outstanding() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (tracker.fail_count == 0 && tracker.outstanding() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
